[sv/ostt_pkg.sv]
// ----------------------------------------------------------------------------
// ostt_pkg: shared definitions for the one-shot timer table
// Sizes, opcodes, status codes, the table entry type and id helpers.
// ----------------------------------------------------------------------------
package ostt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int ID_BITS   = 32;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_CANCEL    = 3'd1;
  localparam logic [2:0] OP_QUERY     = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_CLR_OWNER = 3'd4;
  localparam logic [2:0] OP_CLR_ALL   = 3'd5;
  localparam logic [2:0] OP_SHUTDOWN  = 3'd6;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EXPIRED = 2'd1;
  localparam logic [1:0] STAT_HALTED  = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [31:0]        remaining;
    logic [15:0]        owner;
  } entry_t;

  function automatic logic [31:0] id_low(input logic [ID_BITS-1:0] id);
    logic [63:0] wide;
    wide = 64'(id);
    return wide[31:0];
  endfunction

  function automatic logic id_match(input logic [ID_BITS-1:0] id, input logic [31:0] tid);
    return 64'(id) == 64'(tid);
  endfunction

endpackage

[sv/ostt_req_if.sv]
// ----------------------------------------------------------------------------
// ostt_req_if: command channel of the one-shot timer table
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface ostt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] task_id;
  logic [31:0] delay_us;
  logic [31:0] elapsed_us;
  logic [15:0] owner_tag;

  modport source (output valid, opcode, task_id, delay_us, elapsed_us, owner_tag,
                  input ready);
  modport sink (input valid, opcode, task_id, delay_us, elapsed_us, owner_tag,
                output ready);
endinterface

[sv/ostt_rsp_if.sv]
// ----------------------------------------------------------------------------
// ostt_rsp_if: result channel of the one-shot timer table
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface ostt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic        pending;
  logic        last;

  modport source (output valid, status, result_id, pending, last, input ready);
  modport sink (input valid, status, result_id, pending, last, output ready);
endinterface

[sv/ostt_cell.sv]
// ----------------------------------------------------------------------------
// ostt_cell: one slot of the timer chain
// Holds one entry; loads a new entry or takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module ostt_cell import ostt_pkg::*; (
  input  logic   clk,
  input  logic   shift_en,
  input  logic   load_en,
  input  entry_t shift_in,
  input  entry_t load_in,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      q <= load_in;
    end else if (shift_en) begin
      q <= shift_in;
    end
  end

endmodule

[sv/one_shot_timer_table.sv]
// ----------------------------------------------------------------------------
// one_shot_timer_table: ordered table of one-shot timers
// Add, clear all, shutdown: result registered in the cycle after the transaction.
// Cancel, query, tick, owner clear: the chain shifts one entry per cycle past
// the head cell unless the result is stalled; a final result ends the scan.
// One command in flight; the next is taken once its results are out.
// Reset clears control, count, id counter and halt flag; slots stay unset.
// ----------------------------------------------------------------------------
module one_shot_timer_table import ostt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ostt_req_if.sink   req,
  ostt_rsp_if.source rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic               state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [CNT_W-1:0]   kept, kept_next;
  logic [ID_BITS-1:0] id_counter, id_counter_next;
  logic               halted, halted_next;
  logic               found, found_next;
  logic               have_hold, have_hold_next;
  logic [31:0]        hold_id, hold_id_next;
  logic [2:0]         cur_op;
  logic [31:0]        cur_tid;
  logic [31:0]        cur_elapsed;
  logic [15:0]        cur_owner;

  logic               out_valid;
  logic [1:0]         out_status;
  logic [31:0]        out_id;
  logic               out_pending;
  logic               out_last;

  logic               emit;
  logic [1:0]         emit_status;
  logic [31:0]        emit_id;
  logic               emit_pending;
  logic               emit_last;

  entry_t             cell_q [NUM_SLOTS];
  logic               shift_en;
  logic               load_en;
  logic [IDX_W-1:0]   load_idx;
  entry_t             load_data;

  logic               go;
  logic               take;
  entry_t             head;
  logic               match_id;
  logic [31:0]        sub;
  logic               tick_on;
  logic               expire;
  logic               drop;
  entry_t             kept_entry;
  logic [ID_BITS-1:0] new_id;
  logic [CNT_W-1:0]   wpos;

  assign go        = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && go;
  assign take      = req.valid && req.ready;

  assign head     = cell_q[0];
  assign match_id = id_match(head.id, cur_tid) && (cur_tid != 32'd0);
  assign sub      = (head.remaining > cur_elapsed) ? head.remaining - cur_elapsed : 32'd0;
  assign tick_on  = (cur_op == OP_TICK) && !halted;
  assign expire   = tick_on && (sub == 32'd0);
  assign drop     = expire || ((cur_op == OP_CANCEL) && match_id) ||
                    ((cur_op == OP_CLR_OWNER) && !halted && (cur_owner != 16'd0) &&
                     (head.owner == cur_owner));
  assign new_id   = (id_counter + 1'b1 == '0) ? ID_BITS'(1) : id_counter + 1'b1;
  assign wpos     = rem + kept - 1'b1;

  always_comb begin
    kept_entry = head;
    if (tick_on) begin
      kept_entry.remaining = sub;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rem_next        = rem;
    kept_next       = kept;
    id_counter_next = id_counter;
    halted_next     = halted;
    found_next      = found;
    have_hold_next  = have_hold;
    hold_id_next    = hold_id;
    emit            = 1'b0;
    emit_status     = STAT_DONE;
    emit_id         = 32'd0;
    emit_pending    = 1'b0;
    emit_last       = 1'b1;
    shift_en        = 1'b0;
    load_en         = 1'b0;
    load_idx        = count[IDX_W-1:0];
    load_data       = kept_entry;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (req.opcode) inside
            OP_ADD: begin
              emit = 1'b1;
              if (halted) begin
                emit_status = STAT_HALTED;
              end else if (count == CNT_W'(NUM_SLOTS)) begin
                emit_status = STAT_FULL;
              end else begin
                id_counter_next = new_id;
                count_next      = count + 1'b1;
                load_en         = 1'b1;
                load_data.id        = new_id;
                load_data.remaining = req.delay_us;
                load_data.owner     = req.owner_tag;
                emit_id         = id_low(new_id);
              end
            end
            OP_CANCEL, OP_QUERY, OP_TICK, OP_CLR_OWNER: begin
              state_next     = ST_SCAN;
              rem_next       = count;
              kept_next      = '0;
              found_next     = 1'b0;
              have_hold_next = 1'b0;
            end
            OP_CLR_ALL: begin
              count_next = '0;
              emit       = 1'b1;
            end
            OP_SHUTDOWN: begin
              count_next  = '0;
              halted_next = 1'b1;
              emit        = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (go) begin
          if (rem != '0) begin
            shift_en = 1'b1;
            load_en  = !drop;
            load_idx = wpos[IDX_W-1:0];
            rem_next = rem - 1'b1;
            if (!drop) begin
              kept_next = kept + 1'b1;
            end
            if ((cur_op == OP_QUERY) && match_id) begin
              found_next = 1'b1;
            end
            if (expire) begin
              hold_id_next   = id_low(head.id);
              have_hold_next = 1'b1;
              if (have_hold) begin
                emit        = 1'b1;
                emit_status = STAT_EXPIRED;
                emit_id     = hold_id;
                emit_last   = 1'b0;
              end
            end
          end else begin
            emit       = 1'b1;
            count_next = kept;
            state_next = ST_IDLE;
            if (have_hold) begin
              emit_status = STAT_EXPIRED;
              emit_id     = hold_id;
            end else begin
              emit_pending = found;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    entry_t shift_src;
    if (i < NUM_SLOTS - 1) begin : g_mid
      assign shift_src = cell_q[i+1];
    end else begin : g_tail
      assign shift_src = cell_q[i];
    end
    ostt_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .load_en  (load_en && (load_idx == IDX_W'(i))),
      .shift_in (shift_src),
      .load_in  (load_data),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      id_counter <= '0;
      halted     <= 1'b0;
      have_hold  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      id_counter <= id_counter_next;
      halted     <= halted_next;
      have_hold  <= have_hold_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    kept    <= kept_next;
    found   <= found_next;
    hold_id <= hold_id_next;
    if (take) begin
      cur_op      <= req.opcode;
      cur_tid     <= req.task_id;
      cur_elapsed <= req.elapsed_us;
      cur_owner   <= req.owner_tag;
    end
    if (emit) begin
      out_status  <= emit_status;
      out_id      <= emit_id;
      out_pending <= emit_pending;
      out_last    <= emit_last;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.result_id = out_id;
  assign rsp.pending   = out_pending;
  assign rsp.last      = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_SLOTS))
    else $error("entry count above slot count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, rem} + {1'b0, kept} <= {1'b0, count}))
    else $error("scan positions exceed entry count");

  a_halt_reject: assert property (@(posedge clk) disable iff (rst)
    (take && (req.opcode == OP_ADD) && halted) |=>
      (rsp.valid && (rsp.status == STAT_HALTED) && rsp.last))
    else $error("add after shutdown not rejected");
`endif

endmodule
